// ----- hdl/vfd_char_serial_driver_unit_defines.svh -----
// Assertion macros for the VFD character serial driver.
`ifndef VFD_CHAR_SERIAL_DRIVER_UNIT_DEFINES_SVH
`define VFD_CHAR_SERIAL_DRIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define VFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/vfd_pkg.sv -----
// Types, constants and frame encoding functions for the VFD character serial driver.
package vfd_pkg;

  localparam int FRAME_W   = 20;
  localparam int BITS_W    = 5;
  localparam int DIV_W     = 8;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [BITS_W-1:0] FRAME_LEN   = 5'd20;
  localparam logic [DIV_W-1:0]  DIV_RESET   = 8'd10;
  localparam logic [6:0]        CHAR_MASK   = 7'h7F;
  localparam logic [2:0]        MAX_POS     = 3'd7;
  localparam logic              REG_DIV_IDX = 1'b0;

  typedef struct packed {
    logic [7:0] character;
    logic [7:0] position;
    logic [7:0] dp_mask;
  } in_t;

  typedef struct packed {
    logic              serial_bit;
    logic [BITS_W-1:0] bit_index;
    logic              last_bit;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_SEND,
    ST_LATCH
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic tmr_clr;
  } cmd_t;

  typedef struct packed {
    logic tmr_done;
    logic last;
  } sts_t;

  // Segment ROM: bit 0..7 = A,B,C,D,E,F,G,DP
  function automatic logic [7:0] seg_rom(input logic [6:0] ch);
    logic [7:0] s;
    begin
      case (ch)
        7'd45:   s = 8'h40;
        7'd48:   s = 8'h3F;
        7'd49:   s = 8'h06;
        7'd50:   s = 8'h5B;
        7'd51:   s = 8'h4F;
        7'd52:   s = 8'h66;
        7'd53:   s = 8'h6D;
        7'd54:   s = 8'h7D;
        7'd55:   s = 8'h07;
        7'd56:   s = 8'h7F;
        7'd57:   s = 8'h6F;
        7'd65:   s = 8'h77;
        7'd66:   s = 8'h7F;
        7'd67:   s = 8'h39;
        7'd68:   s = 8'h3F;
        7'd69:   s = 8'h79;
        7'd70:   s = 8'h71;
        7'd71:   s = 8'h7D;
        7'd72:   s = 8'h76;
        7'd73:   s = 8'h06;
        7'd74:   s = 8'h0E;
        7'd76:   s = 8'h38;
        7'd79:   s = 8'h3F;
        7'd80:   s = 8'h73;
        7'd81:   s = 8'hBF;
        7'd82:   s = 8'h77;
        7'd83:   s = 8'h6D;
        7'd84:   s = 8'h07;
        7'd85:   s = 8'h3E;
        7'd117:  s = 8'h4C;
        default: s = 8'h00;
      endcase
      return s;
    end
  endfunction

  function automatic logic [FRAME_W-1:0] grid_bit(input logic [2:0] p);
    logic [FRAME_W-1:0] g;
    begin
      case (p)
        3'd0:    g = 20'h10000;
        3'd1:    g = 20'h00080;
        3'd2:    g = 20'h08000;
        3'd3:    g = 20'h20000;
        3'd4:    g = 20'h04000;
        3'd5:    g = 20'h00040;
        3'd6:    g = 20'h00100;
        default: g = 20'h00008;
      endcase
      return g;
    end
  endfunction

  function automatic logic [FRAME_W-1:0] seg_bit(input logic [2:0] k);
    logic [FRAME_W-1:0] b;
    begin
      case (k)
        3'd0:    b = 20'h00020;
        3'd1:    b = 20'h40000;
        3'd2:    b = 20'h00200;
        3'd3:    b = 20'h01000;
        3'd4:    b = 20'h00800;
        3'd5:    b = 20'h80000;
        3'd6:    b = 20'h00400;
        default: b = 20'h02000;
      endcase
      return b;
    end
  endfunction

  function automatic logic [FRAME_W-1:0] build_frame(input in_t req);
    logic [7:0]         segs;
    logic [2:0]         p;
    logic [FRAME_W-1:0] frame;
    begin
      segs = seg_rom(req.character[6:0] & CHAR_MASK);
      p    = (req.position > 8'd7) ? MAX_POS : req.position[2:0];
      if (req.dp_mask[p]) begin
        segs[7] = 1'b1;
      end
      frame = grid_bit(p);
      for (int k = 0; k < 8; k++) begin
        if (segs[k]) begin
          frame = frame | seg_bit(3'(k));
        end
      end
      return frame;
    end
  endfunction

endpackage

// ----- hdl/vfd_ctrl.sv -----
// Sequencer for request load, shift clock half periods, bit hand-off and load strobe.
module vfd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  vfd_pkg::sts_t   sts,
  output vfd_pkg::cmd_t   cmd
);

  vfd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.shift   = 1'b0;
    cmd.tmr_clr = 1'b0;
    case (state_r)
      vfd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.tmr_clr = 1'b1;
          state_nxt   = vfd_pkg::ST_LO;
        end
      end
      vfd_pkg::ST_LO: begin
        if (sts.tmr_done) begin
          cmd.tmr_clr = 1'b1;
          state_nxt   = vfd_pkg::ST_HI;
        end
      end
      vfd_pkg::ST_HI: begin
        if (sts.tmr_done) begin
          state_nxt = vfd_pkg::ST_SEND;
        end
      end
      vfd_pkg::ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift   = 1'b1;
          cmd.tmr_clr = 1'b1;
          state_nxt   = sts.last ? vfd_pkg::ST_LATCH : vfd_pkg::ST_LO;
        end
      end
      vfd_pkg::ST_LATCH: begin
        // hold one half period for the load strobe
        if (sts.tmr_done) begin
          state_nxt = vfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vfd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/vfd_dp.sv -----
// Frame encoder, frame shift register, bit counter and half-period timer.
module vfd_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vfd_pkg::in_t              in_payload,
  input  logic [vfd_pkg::DIV_W-1:0] divider,
  input  vfd_pkg::cmd_t             cmd,
  output vfd_pkg::sts_t             sts,
  output vfd_pkg::out_t             out_payload
);

  logic [vfd_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [vfd_pkg::BITS_W-1:0]  bits_r, bits_nxt;
  logic [vfd_pkg::DIV_W-1:0]   tmr_r, tmr_nxt;

  always_comb begin
    frame_nxt = frame_r;
    bits_nxt  = bits_r;
    if (cmd.load) begin
      frame_nxt = vfd_pkg::build_frame(in_payload);
      bits_nxt  = vfd_pkg::FRAME_LEN;
    end else if (cmd.shift) begin
      frame_nxt = {frame_r[vfd_pkg::FRAME_W-2:0], 1'b0};
      bits_nxt  = bits_r - 5'd1;
    end
    tmr_nxt = cmd.tmr_clr ? '0 : tmr_r + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
      bits_r  <= '0;
      tmr_r   <= '0;
    end else begin
      frame_r <= frame_nxt;
      bits_r  <= bits_nxt;
      tmr_r   <= tmr_nxt;
    end
  end

  // a divider of zero ends each half period at once
  assign sts.tmr_done = ({1'b0, tmr_r} + 9'd1) >= {1'b0, divider};
  assign sts.last     = (bits_r == 5'd1);

  assign out_payload.serial_bit = frame_r[vfd_pkg::FRAME_W-1];
  assign out_payload.bit_index  = bits_r - 5'd1;
  assign out_payload.last_bit   = (bits_r == 5'd1);

endmodule

// ----- hdl/vfd_char_serial_driver_unit.sv -----
// Top level of the VFD character serial driver: register port, sequencer and datapath.
// Each request yields 20 serial bits; each bit follows a low and a high half period of the shift
// clock, set by the divider register, then waits for hand-off, and a load strobe half period
// follows the last bit. The first bit is offered after the low and high half periods that follow
// the request being taken; one request in flight at a time.
// Synchronous active-low reset clears control state and sets the divider to 10.
`include "vfd_char_serial_driver_unit_defines.svh"

module vfd_char_serial_driver_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vfd_pkg::in_t               in_payload,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vfd_pkg::out_t              out_payload,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vfd_pkg::ADDR_W-1:0] paddr,
  input  logic [vfd_pkg::DATA_W-1:0] pwdata,
  output logic [vfd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [vfd_pkg::DIV_W-1:0] div_r, div_nxt;
  logic                      reg_sel;
  vfd_pkg::cmd_t             cmd;
  vfd_pkg::sts_t             sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == vfd_pkg::REG_DIV_IDX);

  always_comb begin
    div_nxt = div_r;
    if (psel && penable && pwrite && reg_sel) begin
      div_nxt = pwdata[vfd_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= vfd_pkg::DIV_RESET;
    end else begin
      div_r <= div_nxt;
    end
  end

  assign prdata = reg_sel ? {{(vfd_pkg::DATA_W-vfd_pkg::DIV_W){1'b0}}, div_r} : '0;

  vfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vfd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .divider     (div_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_payload (out_payload)
  );

  `VFD_ASSERT_NOW(a_one_in_flight, out_valid, !in_ready, "request taken while a bit is pending")
  `VFD_ASSERT_NOW(a_idx_range, out_valid, out_payload.bit_index <= 5'd19, "bit index out of frame")
  `VFD_ASSERT_NEXT(a_gap_after_bit, out_valid && out_ready, !out_valid, "bit offered without clock period")
  `VFD_ASSERT_NEXT(a_strobe_gap, out_valid && out_ready && out_payload.last_bit, !in_ready, "no load strobe gap")
  `VFD_ASSERT_NEXT(a_load_first, in_valid && in_ready, out_payload.bit_index == 5'd19, "frame not loaded at bit 19")

endmodule

// ----- verif/vfd_char_serial_driver_unit_test.sv -----
// Testbench for the VFD character serial driver: frame prediction, bit-level checks, timing sweeps.
module vfd_char_serial_driver_unit_test;

  localparam logic [vfd_pkg::ADDR_W-1:0] DIV_ADDR   =
    vfd_pkg::ADDR_W'(4 * vfd_pkg::REG_DIV_IDX);
  localparam logic [vfd_pkg::ADDR_W-1:0] SPARE_ADDR = vfd_pkg::ADDR_W'(4);
  localparam int                         TIME_LIMIT = 20_000_000;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  vfd_pkg::in_t                 in_payload;
  logic                         out_valid;
  logic                         out_ready;
  vfd_pkg::out_t                out_payload;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [vfd_pkg::ADDR_W-1:0]   paddr;
  logic [vfd_pkg::DATA_W-1:0]   pwdata;
  logic [vfd_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Predictor tables and state
  logic [7:0]                   seg_table [128];
  logic [vfd_pkg::FRAME_W-1:0]  grid_mask [8];
  logic [vfd_pkg::FRAME_W-1:0]  seg_mask [8];
  logic [vfd_pkg::FRAME_W-1:0]  pred_shifter;
  logic [vfd_pkg::BITS_W-1:0]   pred_bits_left;
  logic [vfd_pkg::DIV_W-1:0]    pred_div;

  vfd_pkg::out_t                expected_bits [$];
  int                           bit_errors;
  int                           hold_cycles;
  bit                           send_gaps_on;
  bit                           recv_stalls_on;

  vfd_char_serial_driver_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < 128; i++) begin
      seg_table[i] = 8'h00;
    end
    seg_table[45] = 8'h40;
    seg_table[48] = 8'h3F; seg_table[49] = 8'h06; seg_table[50] = 8'h5B;
    seg_table[51] = 8'h4F; seg_table[52] = 8'h66; seg_table[53] = 8'h6D;
    seg_table[54] = 8'h7D; seg_table[55] = 8'h07; seg_table[56] = 8'h7F;
    seg_table[57] = 8'h6F;
    seg_table[65] = 8'h77; seg_table[66] = 8'h7F; seg_table[67] = 8'h39;
    seg_table[68] = 8'h3F; seg_table[69] = 8'h79; seg_table[70] = 8'h71;
    seg_table[71] = 8'h7D; seg_table[72] = 8'h76; seg_table[73] = 8'h06;
    seg_table[74] = 8'h0E; seg_table[76] = 8'h38; seg_table[79] = 8'h3F;
    seg_table[80] = 8'h73; seg_table[81] = 8'hBF; seg_table[82] = 8'h77;
    seg_table[83] = 8'h6D; seg_table[84] = 8'h07; seg_table[85] = 8'h3E;
    seg_table[117] = 8'h4C;
    grid_mask[0] = 20'h10000; grid_mask[1] = 20'h00080;
    grid_mask[2] = 20'h08000; grid_mask[3] = 20'h20000;
    grid_mask[4] = 20'h04000; grid_mask[5] = 20'h00040;
    grid_mask[6] = 20'h00100; grid_mask[7] = 20'h00008;
    seg_mask[0] = 20'h00020; seg_mask[1] = 20'h40000;
    seg_mask[2] = 20'h00200; seg_mask[3] = 20'h01000;
    seg_mask[4] = 20'h00800; seg_mask[5] = 20'h80000;
    seg_mask[6] = 20'h00400; seg_mask[7] = 20'h02000;
  end

  // Mostly zero, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Queue the 20 frame bits a request must produce, MSB first
  function automatic void predict_frame_bits(input vfd_pkg::in_t req);
    logic [7:0]    segs;
    logic [2:0]    pos;
    vfd_pkg::out_t bit_exp;
    segs = seg_table[req.character[6:0]];
    pos  = (req.position > 8'd7) ? 3'd7 : req.position[2:0];
    if (req.dp_mask[pos]) segs[7] = 1'b1;
    pred_shifter = grid_mask[pos];
    for (int k = 0; k < 8; k++) begin
      if (segs[k]) pred_shifter = pred_shifter | seg_mask[k];
    end
    pred_bits_left = vfd_pkg::FRAME_LEN;
    while (pred_bits_left != 0) begin
      bit_exp.serial_bit = pred_shifter[vfd_pkg::FRAME_W-1];
      bit_exp.bit_index  = pred_bits_left - 5'd1;
      bit_exp.last_bit   = (pred_bits_left == 5'd1);
      expected_bits.push_back(bit_exp);
      pred_shifter   = pred_shifter << 1;
      pred_bits_left = pred_bits_left - 5'd1;
    end
  endfunction

  // Mostly printable glyphs at real positions; the rest raw bytes
  function automatic vfd_pkg::in_t random_char_req();
    vfd_pkg::in_t req;
    req.character = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 6) begin
      while (seg_table[req.character[6:0]] == 8'h00) begin
        req.character = 8'($urandom_range(0, 255));
      end
    end
    req.position = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                              : 8'($urandom_range(0, 255));
    req.dp_mask  = 8'($urandom_range(0, 255));
    return req;
  endfunction

  // Offer one request and return at the edge that takes it; valid stays high
  task automatic send_char(input vfd_pkg::in_t req);
    int gap;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= req;
    do @(posedge clk); while (!in_ready);
    predict_frame_bits(req);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_char(random_char_req());
    end
  endtask

  // Wait out every expected bit, then the load strobe
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (2 * int'(pred_div) + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vfd_pkg::ADDR_W-1:0] addr,
                           input logic [vfd_pkg::DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == DIV_ADDR) pred_div = data[vfd_pkg::DIV_W-1:0];
  endtask

  task automatic test_directed_chars();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    send_char({8'h00, 8'd0,   8'h00});
    send_char({8'hFF, 8'hFF,  8'hFF});
    send_char({8'h38, 8'd0,   8'h01});
    send_char({8'hB8, 8'd1,   8'h00});
    send_char({8'h51, 8'd2,   8'h00});
    send_char({8'h51, 8'd3,   8'h08});
    send_char({8'h75, 8'd4,   8'h10});
    send_char({8'h2D, 8'd5,   8'hDF});
    send_char({8'h41, 8'd6,   8'h40});
    send_char({8'h5A, 8'd7,   8'h80});
    send_char({8'h30, 8'd8,   8'h80});
    send_char({8'h39, 8'hFF,  8'h7F});
    send_char({8'h7F, 8'h80,  8'h00});
    send_char({8'h45, 8'd7,   8'h00});
    send_char({8'h80, 8'd0,   8'hFE});
    send_char({8'h4A, 8'd1,   8'h02});
    send_char({8'h48, 8'd2,   8'h04});
    send_char({8'h55, 8'd3,   8'hFF});
    drain();
  endtask

  // Writes outside the divider must leave the block untouched
  task automatic test_unmapped_register();
    write_reg(SPARE_ADDR, vfd_pkg::DATA_W'($urandom()));
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    send_random(4);
    drain();
  endtask

  task automatic test_fast_shift();
    write_reg(DIV_ADDR, 32'd1);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    send_random(150);
    drain();
  endtask

  task automatic test_output_backpressure();
    write_reg(DIV_ADDR, 32'd3);
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    hold_cycles    = 400;
    send_random(8);
    // Hold the sender until every bit is out, then resume
    drain();
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    send_random(20);
    drain();
  endtask

  task automatic test_slowest_shift();
    write_reg(DIV_ADDR, 32'd255);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    send_random(3);
    drain();
  endtask

  task automatic test_divider_sweep();
    write_reg(DIV_ADDR, 32'd2);
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    send_random(40);
    drain();
    write_reg(DIV_ADDR, 32'd7);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    send_random(40);
    drain();
    write_reg(DIV_ADDR, 32'd10);
    send_random(40);
    drain();
  endtask

  // Receiver: long hold when asked, else random stalls when enabled
  initial begin
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready   <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if (recv_stalls_on && $urandom_range(0, 9) == 0) stall_left = pick_gap();
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    vfd_pkg::out_t exp_bit;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bits.size() == 0) begin
        bit_errors = bit_errors + 1;
        $display("%0t: unexpected frame bit: serial_bit %0d bit_index %0d last_bit %0d",
                 $time, out_payload.serial_bit, out_payload.bit_index, out_payload.last_bit);
      end else begin
        exp_bit = expected_bits.pop_front();
        if (out_payload.serial_bit !== exp_bit.serial_bit) begin
          bit_errors = bit_errors + 1;
          $display("%0t: serial_bit expected %0d got %0d", $time,
                   exp_bit.serial_bit, out_payload.serial_bit);
        end
        if (out_payload.bit_index !== exp_bit.bit_index) begin
          bit_errors = bit_errors + 1;
          $display("%0t: bit_index expected %0d got %0d", $time,
                   exp_bit.bit_index, out_payload.bit_index);
        end
        if (out_payload.last_bit !== exp_bit.last_bit) begin
          bit_errors = bit_errors + 1;
          $display("%0t: last_bit expected %0d got %0d", $time,
                   exp_bit.last_bit, out_payload.last_bit);
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_payload     = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    bit_errors     = 0;
    hold_cycles    = 0;
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    pred_div       = vfd_pkg::DIV_RESET;
    pred_shifter   = '0;
    pred_bits_left = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_chars();
    test_unmapped_register();
    test_fast_shift();
    test_output_backpressure();
    test_slowest_shift();
    test_divider_sweep();

    if (bit_errors == 0 && expected_bits.size() == 0) begin
      $display("vfd_char_serial_driver_unit_test OK");
    end else begin
      if (expected_bits.size() != 0) begin
        $display("%0t: %0d expected frame bits never arrived", $time, expected_bits.size());
      end
      $display("vfd_char_serial_driver_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #TIME_LIMIT;
    $display("%0t: timeout with %0d frame bits outstanding", $time, expected_bits.size());
    $display("vfd_char_serial_driver_unit_test NOT OK");
    $finish;
  end

endmodule
